@@ rtl/tlnv_pkg.sv @@
// tlnv_pkg: types, constants and register codes shared by the text line filter
// no dependencies; compiled before every other file of the block
`timescale 1ns / 1ps

package tlnv_pkg;

  // digits of the line number field
  localparam int unsigned NumDigits = 6;
  // worst case per input byte: number, two spaces, three bytes for "M-x"
  localparam int unsigned MaxOut    = NumDigits + 2 + 3;
  localparam int unsigned CntW      = $clog2(MaxOut + 1);

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 2;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_NUMBER_MODE      = 3'd0,
    CFG_SHOW_NONPRINTING = 3'd1,
    CFG_SHOW_ENDS        = 3'd2,
    CFG_SHOW_TABS        = 3'd3,
    CFG_SQUEEZE_BLANK    = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    NUM_NONE     = 2'd0,
    NUM_ALL      = 2'd1,
    NUM_NONBLANK = 2'd2,
    NUM_UNUSED   = 2'd3
  } num_mode_e;

  localparam logic [7:0] ChNewline = 8'h0A;
  localparam logic [7:0] ChTab     = 8'h09;
  localparam logic [7:0] ChSpace   = 8'h20;
  localparam logic [7:0] ChZero    = 8'h30;
  localparam logic [7:0] ChCaret   = 8'h5E;
  localparam logic [7:0] ChQuery   = 8'h3F;
  localparam logic [7:0] ChDollar  = 8'h24;
  localparam logic [7:0] ChM       = 8'h4D;
  localparam logic [7:0] ChDash    = 8'h2D;
  localparam logic [7:0] ChDel     = 8'h7F;
  localparam logic [7:0] CtrlLast  = 8'd26;
  localparam logic [7:0] CtrlShift = 8'd64;

  typedef struct packed {
    logic [1:0] number_mode;
    logic       show_nonprinting;
    logic       show_ends;
    logic       show_tabs;
    logic       squeeze_blank;
  } cfg_t;

  // output bytes of one input byte, element 0 goes out first
  typedef struct packed {
    logic [MaxOut-1:0][7:0] bytes;
    logic [CntW-1:0]        cnt;
  } burst_t;

endpackage

@@ rtl/tlnv_in_if.sv @@
// tlnv_in_if: input channel of the text line filter, one raw byte per transaction
// uses no package
`timescale 1ns / 1ps

interface tlnv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       start_of_file;

  modport source (output valid, output in_byte, output start_of_file, input ready);
  modport sink   (input valid, input in_byte, input start_of_file, output ready);
endinterface

@@ rtl/tlnv_out_if.sv @@
// tlnv_out_if: output channel of the text line filter, one character per transaction
// uses no package
`timescale 1ns / 1ps

interface tlnv_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;

  modport source (output valid, output out_byte, output last_of_run, input ready);
  modport sink   (input valid, input out_byte, input last_of_run, output ready);
endinterface

@@ rtl/tlnv_cfg_regs.sv @@
// tlnv_cfg_regs: write-only configuration registers of the text line filter
// depends on tlnv_pkg
`timescale 1ns / 1ps

module tlnv_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tlnv_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [tlnv_pkg::CfgDataW-1:0] cfg_data_i,
  output tlnv_pkg::cfg_t                cfg_o
);
  import tlnv_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_NUMBER_MODE:      cfg_d.number_mode      = cfg_data_i;
        CFG_SHOW_NONPRINTING: cfg_d.show_nonprinting = cfg_data_i[0];
        CFG_SHOW_ENDS:        cfg_d.show_ends        = cfg_data_i[0];
        CFG_SHOW_TABS:        cfg_d.show_tabs        = cfg_data_i[0];
        CFG_SQUEEZE_BLANK:    cfg_d.squeeze_blank    = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ rtl/tlnv_expand.sv @@
// tlnv_expand: input register, line state and the expansion of one byte into a burst
// depends on tlnv_pkg and tlnv_in_if
`timescale 1ns / 1ps

module tlnv_expand (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  tlnv_pkg::cfg_t   cfg_i,
  tlnv_in_if.sink          in_ch,
  output logic             burst_vld_o,
  output tlnv_pkg::burst_t burst_o,
  input  logic             burst_take_i
);
  import tlnv_pkg::*;

  localparam logic [NumDigits-1:0][3:0] LineOne = (NumDigits*4)'(1);

  // input register
  logic       a_vld_q;
  logic [7:0] a_byte_q;
  logic       a_sof_q;
  logic       a_move;

  // line state
  logic [NumDigits-1:0][3:0] line_q, line_d, line_base;
  logic                      prev_nl_q, at_start_q;
  logic [1:0]                run_q, run_d, run_inc;

  logic first, is_nl, drop, want_num, emit_num, visible;
  logic                 carry, lead;
  logic [3:0]           dig;
  logic [NumDigits+1:0][7:0] num_bytes;
  logic [2:0][7:0]      ch_bytes;
  logic [1:0]           ch_n;

  assign a_move      = a_vld_q && burst_take_i;
  assign in_ch.ready = !a_vld_q || burst_take_i;
  assign burst_vld_o = a_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      a_vld_q <= 1'b1;
    end else if (a_move) begin
      a_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ch.valid && in_ch.ready) begin
      a_byte_q <= in_ch.in_byte;
      a_sof_q  <= in_ch.start_of_file;
    end
  end

  // line state and squeeze decision
  always_comb begin
    first    = a_sof_q || at_start_q;
    is_nl    = (a_byte_q == ChNewline);
    run_inc  = (run_q == 2'd3) ? 2'd3 : run_q + 2'd1;
    drop     = !first && cfg_i.squeeze_blank && is_nl && (run_inc == 2'd3);
    if (first) begin
      run_d = 2'd0;
    end else if (cfg_i.squeeze_blank) begin
      run_d = is_nl ? run_inc : 2'd0;
    end else begin
      run_d = run_q;
    end
    want_num = (num_mode_e'(cfg_i.number_mode) == NUM_ALL) ||
               ((num_mode_e'(cfg_i.number_mode) == NUM_NONBLANK) && !is_nl);
    emit_num  = !drop && (first || prev_nl_q) && want_num;
    line_base = first ? LineOne : line_q;
  end

  // saturating bcd increment of the line number
  always_comb begin
    carry = 1'b0;
    for (int i = 0; i < NumDigits; i++) begin
      if (line_base[i] != 4'd9) carry = 1'b1;
    end
    line_d = line_base;
    if (emit_num && carry) begin
      carry = 1'b1;
      for (int i = 0; i < NumDigits; i++) begin
        if (carry) begin
          if (line_base[i] >= 4'd9) begin
            line_d[i] = 4'd0;
          end else begin
            line_d[i] = line_base[i] + 4'd1;
            carry     = 1'b0;
          end
        end
      end
    end
  end

  // space-padded decimal field and two spaces
  always_comb begin
    lead = 1'b1;
    dig  = 4'd0;
    for (int i = NumDigits - 1; i >= 0; i--) begin
      dig = (line_base[i] > 4'd9) ? 4'd9 : line_base[i];
      if (dig != 4'd0 || i == 0) lead = 1'b0;
      num_bytes[NumDigits-1-i] = lead ? ChSpace : ChZero + {4'd0, dig};
    end
    num_bytes[NumDigits]   = ChSpace;
    num_bytes[NumDigits+1] = ChSpace;
  end

  // rendering of the byte itself
  always_comb begin
    visible  = cfg_i.show_nonprinting || cfg_i.show_tabs || cfg_i.show_ends;
    ch_bytes = '0;
    ch_n     = 2'd1;
    ch_bytes[0] = a_byte_q;
    if (visible) begin
      priority if (is_nl) begin
        if (cfg_i.show_ends) begin
          ch_bytes[0] = ChDollar;
          ch_bytes[1] = ChNewline;
          ch_n        = 2'd2;
        end
      end else if (a_byte_q == ChTab && cfg_i.show_tabs) begin
        ch_bytes[0] = ChCaret;
        ch_bytes[1] = a_byte_q + CtrlShift;
        ch_n        = 2'd2;
      end else if (a_byte_q >= 8'd1 && a_byte_q <= CtrlLast && a_byte_q != ChTab) begin
        ch_bytes[0] = ChCaret;
        ch_bytes[1] = a_byte_q + CtrlShift;
        ch_n        = 2'd2;
      end else if (a_byte_q == ChDel) begin
        ch_bytes[0] = ChCaret;
        ch_bytes[1] = ChQuery;
        ch_n        = 2'd2;
      end else if (a_byte_q[7]) begin
        ch_bytes[0] = ChM;
        ch_bytes[1] = ChDash;
        ch_bytes[2] = {1'b0, a_byte_q[6:0]};
        ch_n        = 2'd3;
      end else begin
        ch_n = 2'd1;
      end
    end
  end

  // assemble the burst
  always_comb begin
    burst_o = '0;
    if (drop) begin
      burst_o.cnt = '0;
    end else if (emit_num) begin
      for (int i = 0; i < NumDigits + 2; i++) begin
        burst_o.bytes[i] = num_bytes[i];
      end
      for (int k = 0; k < 3; k++) begin
        burst_o.bytes[NumDigits+2+k] = ch_bytes[k];
      end
      burst_o.cnt = CntW'(NumDigits + 2) + CntW'(ch_n);
    end else begin
      for (int k = 0; k < 3; k++) begin
        burst_o.bytes[k] = ch_bytes[k];
      end
      burst_o.cnt = CntW'(ch_n);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_q     <= LineOne;
      prev_nl_q  <= 1'b0;
      at_start_q <= 1'b1;
      run_q      <= 2'd0;
    end else if (a_move) begin
      line_q     <= line_d;
      at_start_q <= 1'b0;
      run_q      <= run_d;
      if (!drop) prev_nl_q <= is_nl;
    end
  end

endmodule

@@ rtl/tlnv_serial.sv @@
// tlnv_serial: result register holding one burst, shifted out a byte per transaction
// depends on tlnv_pkg and tlnv_out_if
`timescale 1ns / 1ps

module tlnv_serial (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             burst_vld_i,
  input  tlnv_pkg::burst_t burst_i,
  output logic             burst_take_o,
  tlnv_out_if.source       out_ch
);
  import tlnv_pkg::*;

  logic [MaxOut-1:0][7:0] bytes_q;
  logic [CntW-1:0]        rem_q;
  logic                   fire;

  assign out_ch.valid       = (rem_q != '0);
  assign out_ch.out_byte    = bytes_q[0];
  assign out_ch.last_of_run = (rem_q == CntW'(1));
  assign fire               = out_ch.valid && out_ch.ready;
  // free now, or freed by the final byte going out this cycle
  assign burst_take_o       = (rem_q == '0) || (fire && out_ch.last_of_run);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
    end else if (burst_take_o && burst_vld_i) begin
      rem_q <= burst_i.cnt;
    end else if (fire) begin
      rem_q <= rem_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (burst_take_o && burst_vld_i) begin
      bytes_q <= burst_i.bytes;
    end else if (fire) begin
      bytes_q <= {8'd0, bytes_q[MaxOut-1:1]};
    end
  end

endmodule

@@ rtl/text_line_number_visible_filter.sv @@
// text_line_number_visible_filter: top level of the line numbering / visible text filter
// depends on tlnv_pkg, tlnv_in_if, tlnv_out_if, tlnv_cfg_regs, tlnv_expand, tlnv_serial
//
//   channel   direction  width        transaction
//   in_ch_i   sink       8 + 1        raw byte, start of file flag
//   out_ch_o  source     8 + 1        one character, last of run flag
//   cfg       write      3 idx, 2 dat one register write per cycle with cfg_we_i
//
// an input byte is held in the input register, which forms its burst (0 to 11 characters)
// each burst goes out at one character per cycle while out_ch_o is ready; a byte with a single
// character sustains one transaction per cycle, an n-character burst holds the input to its end
// the input register takes the next byte while the result register is still draining
// reset clears the line number to one and the configuration to zero; no clearing pass
`timescale 1ns / 1ps

module text_line_number_visible_filter (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tlnv_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [tlnv_pkg::CfgDataW-1:0] cfg_data_i,
  tlnv_in_if.sink                       in_ch_i,
  tlnv_out_if.source                    out_ch_o
);
  import tlnv_pkg::*;

  cfg_t   cfg;
  burst_t burst;
  logic   burst_vld;
  logic   burst_take;

  tlnv_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  tlnv_expand u_expand (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .in_ch        (in_ch_i),
    .burst_vld_o  (burst_vld),
    .burst_o      (burst),
    .burst_take_i (burst_take)
  );

  tlnv_serial u_serial (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .burst_vld_i  (burst_vld),
    .burst_i      (burst),
    .burst_take_o (burst_take),
    .out_ch       (out_ch_o)
  );

endmodule

@@ tb/sv/tlnv_text_checker.sv @@
// tlnv_text_checker: watches both channels and the register port of the text line filter,
// predicts every character from its own copy of the filter state and compares in order
// depends on tlnv_pkg, tlnv_in_if and tlnv_out_if
`timescale 1ns / 1ps

module tlnv_text_checker
  import tlnv_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  tlnv_in_if                  in_ch_i,
  tlnv_out_if                 out_ch_i,
  output int                  mismatches_o,
  output int                  pending_o
);

  typedef struct {
    logic [7:0] ch;
    logic       last;
  } text_char_t;

  text_char_t expected_chars[$];
  text_char_t head;
  int         mismatches = 0;

  // copy of the register file
  num_mode_e num_mode;
  logic      show_ctrl;
  logic      mark_ends;
  logic      mark_tabs;
  logic      squeeze;

  // copy of the line state
  logic [4*NumDigits-1:0] line_no;
  logic                   prev_nl;
  logic                   file_start;
  logic [1:0]             nl_run;

  assign mismatches_o = mismatches;

  task automatic report_mismatch(input string what);
    if (mismatches < 100) $display("%0t ns: text filter mismatch: %s", $time, what);
    mismatches++;
  endtask

  function automatic void queue_char(input logic [7:0] c);
    text_char_t t;
    t.ch   = c;
    t.last = 1'b0;
    expected_chars.push_back(t);
  endfunction

  // saturating BCD increment of the line number
  function automatic void bump_line_no();
    logic [3:0] d;
    logic       all_nine;
    logic       carry;
    all_nine = 1'b1;
    for (int i = 0; i < NumDigits; i++) begin
      if (line_no[4*i +: 4] != 4'd9) all_nine = 1'b0;
    end
    if (all_nine) return;
    carry = 1'b1;
    for (int i = 0; i < NumDigits; i++) begin
      if (carry) begin
        d = line_no[4*i +: 4];
        if (d >= 4'd9) begin
          line_no[4*i +: 4] = 4'd0;
        end else begin
          line_no[4*i +: 4] = d + 4'd1;
          carry = 1'b0;
        end
      end
    end
  endfunction

  function automatic void queue_line_no();
    logic [3:0] d;
    logic       lead;
    lead = 1'b1;
    for (int i = NumDigits - 1; i >= 0; i--) begin
      d = line_no[4*i +: 4];
      if (d > 4'd9) d = 4'd9;
      if (d != 4'd0 || i == 0) lead = 1'b0;
      queue_char(lead ? ChSpace : ChZero + 8'(d));
    end
    queue_char(ChSpace);
    queue_char(ChSpace);
    bump_line_no();
  endfunction

  function automatic logic wants_number(input logic is_nl);
    return num_mode == NUM_ALL || (num_mode == NUM_NONBLANK && !is_nl);
  endfunction

  function automatic void queue_rendered(input logic [7:0] c);
    if (!(show_ctrl || mark_tabs || mark_ends)) begin
      queue_char(c);
    end else if (c == ChNewline) begin
      if (mark_ends) queue_char(ChDollar);
      queue_char(c);
    end else if (c == ChTab && mark_tabs) begin
      queue_char(ChCaret);
      queue_char(c + CtrlShift);
    end else if (c >= 8'd1 && c <= CtrlLast && c != ChTab) begin
      queue_char(ChCaret);
      queue_char(c + CtrlShift);
    end else if (c == ChDel) begin
      queue_char(ChCaret);
      queue_char(ChQuery);
    end else if (c[7]) begin
      queue_char(ChM);
      queue_char(ChDash);
      queue_char({1'b0, c[6:0]});
    end else begin
      queue_char(c);
    end
  endfunction

  function automatic void predict_text(input logic [7:0] c, input logic sof);
    logic is_nl;
    int   base;
    is_nl = (c == ChNewline);
    base  = expected_chars.size();
    if (sof || file_start) begin
      file_start = 1'b0;
      line_no    = (4*NumDigits)'(1);
      nl_run     = 2'd0;
      if (wants_number(is_nl)) queue_line_no();
    end else begin
      if (squeeze) begin
        if (is_nl) begin
          if (nl_run < 2'd3) nl_run++;
          // third newline in a row and beyond: dropped, nothing else moves
          if (nl_run > 2'd2) return;
        end else begin
          nl_run = 2'd0;
        end
      end
      if (prev_nl && wants_number(is_nl)) queue_line_no();
    end
    prev_nl = is_nl;
    queue_rendered(c);
    if (expected_chars.size() > base) expected_chars[$].last = 1'b1;
  endfunction

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      num_mode   = NUM_NONE;
      show_ctrl  = 1'b0;
      mark_ends  = 1'b0;
      mark_tabs  = 1'b0;
      squeeze    = 1'b0;
      line_no    = (4*NumDigits)'(1);
      prev_nl    = 1'b0;
      file_start = 1'b1;
      nl_run     = 2'd0;
      expected_chars.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_NUMBER_MODE:      num_mode  = num_mode_e'(cfg_data_i);
          CFG_SHOW_NONPRINTING: show_ctrl = cfg_data_i[0];
          CFG_SHOW_ENDS:        mark_ends = cfg_data_i[0];
          CFG_SHOW_TABS:        mark_tabs = cfg_data_i[0];
          CFG_SQUEEZE_BLANK:    squeeze   = cfg_data_i[0];
          default: ;
        endcase
      end
      // a byte is taken before any of its characters can leave
      if (in_ch_i.valid && in_ch_i.ready) begin
        predict_text(in_ch_i.in_byte, in_ch_i.start_of_file);
      end
      if (out_ch_i.valid && out_ch_i.ready) begin
        if (expected_chars.size() == 0) begin
          report_mismatch($sformatf("unexpected character %02h", out_ch_i.out_byte));
        end else begin
          head = expected_chars.pop_front();
          if (out_ch_i.out_byte !== head.ch) begin
            report_mismatch($sformatf("out_byte %02h, expected %02h",
                                      out_ch_i.out_byte, head.ch));
          end
          if (out_ch_i.last_of_run !== head.last) begin
            report_mismatch($sformatf("last_of_run %b, expected %b on character %02h",
                                      out_ch_i.last_of_run, head.last, head.ch));
          end
        end
      end
      pending_o <= expected_chars.size();
    end
  end

endmodule

@@ tb/sv/tb_top.sv @@
// tb_top: stimulus and verdict for the text line filter; directed bytes, then random text
// in phases under different register settings, with random gaps and stalls on both sides
// depends on tlnv_pkg, tlnv_in_if, tlnv_out_if, text_line_number_visible_filter, tlnv_text_checker
`timescale 1ns / 1ps

module tb_top;
  import tlnv_pkg::*;

  localparam logic [CfgIdxW-1:0] CfgIdxSpare = 3'd7;
  localparam int                 HoldCycles  = 80;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_data;
  int                  mismatches;
  int                  pending;
  int                  sent_count = 0;

  tlnv_in_if  in_ch ();
  tlnv_out_if out_ch ();

  text_line_number_visible_filter dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_ch_i    (in_ch),
    .out_ch_o   (out_ch)
  );

  tlnv_text_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .in_ch_i      (in_ch),
    .out_ch_i     (out_ch),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

  // one byte transaction; valid stays high when the next byte follows without a gap
  task automatic send_text(input logic [7:0] c, input logic sof);
    int gap;
    gap = (((sent_count / 40) % 3) == 2) ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid         <= 1'b1;
    in_ch.in_byte       <= c;
    in_ch.start_of_file <= sof;
    do @(posedge clk_i); while (!in_ch.ready);
    sent_count++;
  endtask

  // a dropped newline gives no characters, so keep waiting beyond the last expected one
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic setup(input num_mode_e nm, input logic vis, input logic ends,
                       input logic tabs, input logic sq, input logic spare);
    wait_idle();
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_NUMBER_MODE;
    cfg_data <= nm;
    @(posedge clk_i);
    // upper data bit is don't-care for the one-bit registers
    cfg_idx  <= CFG_SHOW_NONPRINTING;
    cfg_data <= {1'($urandom_range(0, 1)), vis};
    @(posedge clk_i);
    cfg_idx  <= CFG_SHOW_ENDS;
    cfg_data <= {1'($urandom_range(0, 1)), ends};
    @(posedge clk_i);
    cfg_idx  <= CFG_SHOW_TABS;
    cfg_data <= {1'($urandom_range(0, 1)), tabs};
    @(posedge clk_i);
    cfg_idx  <= CFG_SQUEEZE_BLANK;
    cfg_data <= {1'($urandom_range(0, 1)), sq};
    @(posedge clk_i);
    if (spare) begin
      cfg_idx  <= CfgIdxSpare;
      cfg_data <= 2'($urandom_range(0, 3));
      @(posedge clk_i);
    end
    cfg_we <= 1'b0;
  endtask

  // lines of text with newline runs, tabs, controls and high bytes mixed in
  task automatic send_random_text(input int n);
    int         k;
    int         kind;
    int         run;
    logic [7:0] c;
    k = 0;
    while (k < n) begin
      kind = $urandom_range(0, 99);
      if (kind < 25) begin
        run = $urandom_range(1, 4);
        repeat (run) send_text(ChNewline, $urandom_range(0, 39) == 0);
        k += run;
      end else begin
        if (kind < 35)      c = ChTab;
        else if (kind < 50) c = 8'($urandom_range(0, 255));
        else if (kind < 58) c = 8'($urandom_range(0, 31));
        else                c = 8'($urandom_range(32, 126));
        send_text(c, $urandom_range(0, 29) == 0);
        k++;
      end
    end
  endtask

  // receiver: random stall per character, a run without stalls now and then,
  // and a long hold-off so the input backs up
  initial begin
    int gap;
    int taken;
    out_ch.ready = 1'b0;
    taken = 0;
    @(posedge rst_ni);
    forever begin
      gap = (((taken / 60) % 3) == 1) ? 0 : $urandom_range(0, 4);
      if (taken % 500 == 100) gap = HoldCycles;
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!out_ch.valid);
      taken++;
    end
  end

  initial begin
    int guard;
    rst_ni              = 1'b0;
    cfg_we              = 1'b0;
    cfg_idx             = CFG_NUMBER_MODE;
    cfg_data            = '0;
    in_ch.valid         = 1'b0;
    in_ch.in_byte       = '0;
    in_ch.start_of_file = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // everything visible, numbering and squeeze on; first byte relies on reset state
    setup(NUM_ALL, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0);
    send_text(8'h41, 1'b0);
    send_text(8'h00, 1'b0);
    send_text(ChTab, 1'b0);
    send_text(8'h01, 1'b0);
    send_text(CtrlLast, 1'b0);
    send_text(8'h1B, 1'b0);
    send_text(8'h1F, 1'b0);
    send_text(ChDel, 1'b0);
    send_text(8'h80, 1'b0);
    send_text(8'hFF, 1'b0);
    send_text(8'h7E, 1'b0);
    send_text(ChNewline, 1'b0);
    send_text(ChNewline, 1'b0);
    send_text(ChNewline, 1'b0);
    send_text(ChNewline, 1'b0);
    send_text(8'h7A, 1'b0);
    send_text(ChNewline, 1'b1);

    // non-blank numbering, plain rendering, write to an unused register index
    setup(NUM_NONBLANK, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1);
    send_text(ChNewline, 1'b1);
    send_text(ChNewline, 1'b0);
    send_text(ChTab, 1'b0);
    send_text(8'h80, 1'b0);
    send_text(ChNewline, 1'b0);

    // unused numbering code, visible without tabs
    setup(NUM_UNUSED, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
    send_text(ChTab, 1'b0);
    send_text(8'h9B, 1'b0);
    send_text(ChNewline, 1'b0);
    send_text(8'h71, 1'b0);

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: setup(NUM_NONBLANK, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
        1: setup(NUM_NONE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        2: setup(NUM_ALL, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0);
        3: setup(NUM_UNUSED, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)), 1'b1, 1'b0);
        default: setup(num_mode_e'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                       1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                       1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      endcase
      send_random_text(44);
    end

    in_ch.valid <= 1'b0;
    guard = 0;
    do begin
      @(posedge clk_i);
      guard++;
    end while (pending != 0 && guard < 20000);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
